>>> src/mpds_pkg.sv
// mpds_pkg: shared types and constants for the motor pair drive shaper
// holds the operation codes, register indexes, configuration, state and result structs
// used by mpds_core and motor_pair_drive_shaper
package mpds_pkg;

	typedef enum logic [1:0] {
		OP_DRIVE       = 2'd0,
		OP_STOP        = 2'd1,
		OP_CHECK       = 2'd2,
		OP_RESET_STALL = 2'd3
	} op_t;

	localparam int unsigned RegIdxW = 3;

	localparam logic [RegIdxW-1:0] REG_SLEW_LIMIT      = 3'd0;
	localparam logic [RegIdxW-1:0] REG_DUTY_LIMIT      = 3'd1;
	localparam logic [RegIdxW-1:0] REG_DEADZONE_EDGE   = 3'd2;
	localparam logic [RegIdxW-1:0] REG_STALL_DUTY_MIN  = 3'd3;
	localparam logic [RegIdxW-1:0] REG_STALL_SPEED_MAX = 3'd4;
	localparam logic [RegIdxW-1:0] REG_STALL_TIMEOUT   = 3'd5;

	localparam logic [14:0] SLEW_LIMIT_RST      = 15'd5;
	localparam logic [14:0] DUTY_LIMIT_RST      = 15'd80;
	localparam logic [14:0] DEADZONE_EDGE_RST   = 15'd15;
	localparam logic [14:0] STALL_DUTY_MIN_RST  = 15'd60;
	localparam logic [15:0] STALL_SPEED_MAX_RST = 16'd50;
	localparam logic [15:0] STALL_TIMEOUT_RST   = 16'd1000;

	typedef struct packed {
		logic [14:0] slew_limit;
		logic [14:0] duty_limit;
		logic [14:0] deadzone_edge;
		logic [14:0] stall_duty_min;
		logic [15:0] stall_speed_max;
		logic [15:0] stall_timeout;
	} cfg_t;

	typedef struct packed {
		logic [15:0] stored_duty;
		logic        stall_tracking;
		logic [31:0] stall_start_time;
	} state_t;

	typedef struct packed {
		logic [15:0] left_duty;
		logic [15:0] right_duty;
		logic        motor_update;
		logic        stall_flag;
	} result_t;

	// magnitude of a signed 16-bit duty kept within +/- 32767
	function automatic logic [15:0] duty_mag(input logic [15:0] d);
		logic [15:0] m;
		m = d[15] ? (16'd0 - d) : d;
		return m;
	endfunction

endpackage

>>> src/mpds_core.sv
// mpds_core: single-pass datapath for one item of the drive shaper
// computes the result word and the next state from the current state and config
// depends on mpds_pkg
module mpds_core (
	input  logic [1:0]            operation,
	input  logic [15:0]           duty_request,
	input  logic [15:0]           encoder_speed,
	input  logic [31:0]           now_ms,
	input  mpds_pkg::cfg_t        cfg,
	input  mpds_pkg::state_t      cur,
	output mpds_pkg::state_t      nxt,
	output mpds_pkg::result_t     res
);
	import mpds_pkg::*;

	logic signed [17:0] req_x;
	logic signed [17:0] sd_x;
	logic signed [17:0] slew_x;
	logic signed [17:0] lim_x;
	logic signed [17:0] delta;
	logic signed [17:0] slewed;
	logic signed [17:0] clamped;
	logic [15:0]        d16;
	logic [15:0]        d_mag;
	logic [15:0]        dz16;
	logic [15:0]        right_drv;
	logic [15:0]        stored_mag;
	logic               stall_cond;
	logic [31:0]        start_eff;
	logic [31:0]        elapsed;
	logic               stall_hit;

	// slew limit, then clamp to the duty bound
	always_comb begin
		req_x  = {{2{duty_request[15]}}, duty_request};
		sd_x   = {{2{cur.stored_duty[15]}}, cur.stored_duty};
		slew_x = {3'b000, cfg.slew_limit};
		lim_x  = {3'b000, cfg.duty_limit};
		delta  = req_x - sd_x;
		if (delta > slew_x) begin
			slewed = sd_x + slew_x;
		end else if (delta < -slew_x) begin
			slewed = sd_x - slew_x;
		end else begin
			slewed = req_x;
		end
		if (slewed > lim_x) begin
			clamped = lim_x;
		end else if (slewed < -lim_x) begin
			clamped = -lim_x;
		end else begin
			clamped = slewed;
		end
	end

	// deadzone raise on nonzero duties below the edge
	always_comb begin
		d16   = clamped[15:0];
		d_mag = duty_mag(d16);
		dz16  = {1'b0, cfg.deadzone_edge};
		if (d16 == 16'd0) begin
			right_drv = 16'd0;
		end else if (d_mag < dz16) begin
			right_drv = d16[15] ? (16'd0 - dz16) : dz16;
		end else begin
			right_drv = d16;
		end
	end

	// stall check, elapsed time wraps mod 2^32
	always_comb begin
		stored_mag = duty_mag(cur.stored_duty);
		stall_cond = (stored_mag >= {1'b0, cfg.stall_duty_min}) &&
			($signed(encoder_speed) <= $signed(cfg.stall_speed_max));
		start_eff  = cur.stall_tracking ? cur.stall_start_time : now_ms;
		elapsed    = now_ms - start_eff;
		stall_hit  = stall_cond && (elapsed >= {16'd0, cfg.stall_timeout});
	end

	always_comb begin
		nxt = cur;
		res = '0;
		case (operation)
			OP_DRIVE: begin
				nxt.stored_duty  = d16;
				res.right_duty   = right_drv;
				res.left_duty    = 16'd0 - right_drv;
				res.motor_update = 1'b1;
			end
			OP_STOP: begin
				nxt.stored_duty  = 16'd0;
				res.motor_update = 1'b1;
			end
			OP_CHECK: begin
				nxt.stall_tracking   = stall_cond;
				nxt.stall_start_time = stall_cond ? start_eff : cur.stall_start_time;
				res.stall_flag       = stall_hit;
			end
			default: begin
				nxt.stall_tracking   = 1'b0;
				nxt.stall_start_time = 32'd0;
			end
		endcase
	end

endmodule

>>> src/motor_pair_drive_shaper.sv
// motor_pair_drive_shaper: slew-limited, deadzone-compensated drive for a mirrored motor pair
// top level with input register, result register, state and APB config registers
// depends on mpds_pkg and mpds_core
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata: request, speed, now_ms; tuser: operation
//  m_*      | out | m_tvalid/m_tready  | tdata: left, right, motor_update, stall_flag
//  apb      | in  | psel/penable/pready| six config registers at 4*index
//
// one item per cycle sustained while results are taken; an item waits in the input register,
// where the datapath updates the state, then sits in the result register
// the input side stalls only when the result register is full and not taken
// arst_n clears the pipeline valids and state and reloads the register defaults
module motor_pair_drive_shaper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [15:0] duty_request, [31:16] encoder_speed, [63:32] now_ms
	input  logic [1:0]  s_tuser,  // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [15:0] left_duty, [31:16] right_duty, [32] motor_update,
	                              // [33] stall_flag, [39:34] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mpds_pkg::*;

	cfg_t        cfg_q;
	state_t      state_q;
	state_t      state_nxt;
	result_t     res;
	result_t     res_s2;
	logic        valid_s1;
	logic        valid_s2;
	logic [1:0]  op_s1;
	logic [15:0] req_s1;
	logic [15:0] speed_s1;
	logic [31:0] now_s1;
	logic        advance;
	logic [RegIdxW-1:0] reg_idx;
	logic        cfg_wr;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.stall_flag, res_s2.motor_update,
		res_s2.right_duty, res_s2.left_duty};

	mpds_core u_core (
		.operation     (op_s1),
		.duty_request  (req_s1),
		.encoder_speed (speed_s1),
		.now_ms        (now_s1),
		.cfg           (cfg_q),
		.cur           (state_q),
		.nxt           (state_nxt),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			req_s1   <= s_tdata[15:0];
			speed_s1 <= s_tdata[31:16];
			now_s1   <= s_tdata[63:32];
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	// config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slew_limit      <= SLEW_LIMIT_RST;
			cfg_q.duty_limit      <= DUTY_LIMIT_RST;
			cfg_q.deadzone_edge   <= DEADZONE_EDGE_RST;
			cfg_q.stall_duty_min  <= STALL_DUTY_MIN_RST;
			cfg_q.stall_speed_max <= STALL_SPEED_MAX_RST;
			cfg_q.stall_timeout   <= STALL_TIMEOUT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SLEW_LIMIT:      cfg_q.slew_limit      <= pwdata[14:0];
				REG_DUTY_LIMIT:      cfg_q.duty_limit      <= pwdata[14:0];
				REG_DEADZONE_EDGE:   cfg_q.deadzone_edge   <= pwdata[14:0];
				REG_STALL_DUTY_MIN:  cfg_q.stall_duty_min  <= pwdata[14:0];
				REG_STALL_SPEED_MAX: cfg_q.stall_speed_max <= pwdata[15:0];
				REG_STALL_TIMEOUT:   cfg_q.stall_timeout   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SLEW_LIMIT:      prdata = {17'd0, cfg_q.slew_limit};
			REG_DUTY_LIMIT:      prdata = {17'd0, cfg_q.duty_limit};
			REG_DEADZONE_EDGE:   prdata = {17'd0, cfg_q.deadzone_edge};
			REG_STALL_DUTY_MIN:  prdata = {17'd0, cfg_q.stall_duty_min};
			REG_STALL_SPEED_MAX: prdata = {16'd0, cfg_q.stall_speed_max};
			REG_STALL_TIMEOUT:   prdata = {16'd0, cfg_q.stall_timeout};
			default:             prdata = 32'd0;
		endcase
	end

`ifndef SYNTHESIS
	// an empty result register never holds off the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// a result never both updates the motors and flags a stall
	a_update_xor_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
		else $error("result with motor update and stall flag");

	// a stall flag waiting at the output implies stall tracking is active
	a_stall_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[33]) |-> state_q.stall_tracking)
		else $error("stall flagged without tracking");

	// after a drive the stored duty lies within the duty bound
	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_s1 == OP_DRIVE)) |=>
		(duty_mag(state_q.stored_duty) <= {1'b0, $past(cfg_q.duty_limit)}))
		else $error("stored duty beyond duty limit");
`endif

endmodule
